### hdl/multi_waveform_dac_generator_core_assert.svh
// Assertion macros shared by the waveform generator RTL.
// Depends on nothing; included by the top level for its concurrent checks.
`ifndef MULTI_WAVEFORM_DAC_GENERATOR_CORE_ASSERT_SVH
`define MULTI_WAVEFORM_DAC_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MWDG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("waveform generator assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MWDG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("waveform generator assertion failed");

`endif

### hdl/mwdg_pkg.sv
// Package for the waveform generator: widths, mode and register codes, and the
// per-waveform sample code tables built at elaboration. Depends on nothing.
`default_nettype none

package mwdg_pkg;

    localparam int IDX_W  = 8;
    localparam int CODE_W = 8;
    localparam int HOLD_W = 16;
    localparam int DAC_W  = 16;
    localparam int CFG_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam int RAMP_STEPS     = 100;
    localparam int TRIANGLE_STEPS = 200;
    localparam int SINE_STEPS     = 96;
    localparam int PEAK_CODE      = 127;
    localparam int SINE_TABLE_LEN = 96;
    localparam int HIGH_LEVEL     = 255;
    localparam int TABLE_DEPTH    = 1 << IDX_W;

    localparam logic [3:0] DAC_PREFIX = 4'h3;
    localparam logic [3:0] DAC_FILL   = 4'hF;

    localparam logic [2:0] MODE_TRIANGLE  = 3'd0;
    localparam logic [2:0] MODE_RAMP_UP   = 3'd1;
    localparam logic [2:0] MODE_RAMP_DOWN = 3'd2;
    localparam logic [2:0] MODE_SQUARE    = 3'd3;
    localparam logic [2:0] MODE_SINE      = 3'd4;
    localparam logic [2:0] MODE_PULSE     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_HOLD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_HOLD    = 2'd3;

    localparam logic [HOLD_W-1:0] SAMPLE_HOLD_RESET = 16'd20000;
    localparam logic [HOLD_W-1:0] HIGH_HOLD_RESET   = 16'd100;
    localparam logic [HOLD_W-1:0] LOW_HOLD_RESET    = 16'd100;

    typedef logic [CODE_W-1:0] code_tbl_t [TABLE_DEPTH];

    // Status of the sequencer toward the sample map and the top level.
    typedef struct packed {
        logic [IDX_W-1:0] index_next;
        logic             fresh;
        logic [IDX_W-1:0] index;
    } seq_status_t;

    localparam logic [CODE_W-1:0] SINE_ROM [SINE_TABLE_LEN] = '{
        8'd127, 8'd135, 8'd143, 8'd151, 8'd159, 8'd156, 8'd166, 8'd174,
        8'd181, 8'd188, 8'd195, 8'd202, 8'd214, 8'd220, 8'd225, 8'd230,
        8'd234, 8'd238, 8'd242, 8'd245, 8'd248, 8'd252, 8'd253, 8'd254,
        8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd245, 8'd242, 8'd238,
        8'd230, 8'd225, 8'd220, 8'd214, 8'd208, 8'd202, 8'd195, 8'd188,
        8'd181, 8'd174, 8'd166, 8'd159, 8'd151, 8'd145, 8'd135, 8'd127,
        8'd119, 8'd111, 8'd103, 8'd95,  8'd88,  8'd80,  8'd73,  8'd66,
        8'd59,  8'd52,  8'd46,  8'd40,  8'd34,  8'd29,  8'd24,  8'd16,
        8'd12,  8'd9,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0,   8'd0,
        8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd9,   8'd12,  8'd16,
        8'd20,  8'd24,  8'd29,  8'd34,  8'd40,  8'd46,  8'd52,  8'd59,
        8'd66,  8'd73,  8'd80,  8'd88,  8'd95,  8'd103, 8'd111, 8'd119
    };

    // Builds the code of every index for one waveform. An index at or beyond
    // the waveform length takes the code of index zero.
    function automatic code_tbl_t build_code_table(input logic [2:0] wave);
        code_tbl_t t;
        int len;
        int i;
        int k;
        int v;
        case (wave)
            MODE_RAMP_UP, MODE_RAMP_DOWN: len = RAMP_STEPS;
            MODE_SQUARE:                  len = 2;
            MODE_SINE:                    len = SINE_STEPS;
            default:                      len = TRIANGLE_STEPS;
        endcase
        for (i = 0; i < TABLE_DEPTH; i++) begin
            k = (i < len) ? i : 0;
            case (wave)
                MODE_RAMP_UP:   v = k * PEAK_CODE / RAMP_STEPS;
                MODE_RAMP_DOWN: v = (RAMP_STEPS - k) * PEAK_CODE / RAMP_STEPS;
                MODE_SQUARE:    v = (k == 0) ? HIGH_LEVEL : 0;
                MODE_SINE:      v = SINE_ROM[k % SINE_TABLE_LEN];
                default: begin
                    if (k < TRIANGLE_STEPS / 2) begin
                        v = k * PEAK_CODE / TRIANGLE_STEPS;
                    end else begin
                        v = (TRIANGLE_STEPS - k) * PEAK_CODE / TRIANGLE_STEPS;
                    end
                end
            endcase
            t[i] = v[CODE_W-1:0];
        end
        return t;
    endfunction

    localparam code_tbl_t TRIANGLE_TBL  = build_code_table(MODE_TRIANGLE);
    localparam code_tbl_t RAMP_UP_TBL   = build_code_table(MODE_RAMP_UP);
    localparam code_tbl_t RAMP_DOWN_TBL = build_code_table(MODE_RAMP_DOWN);
    localparam code_tbl_t SQUARE_TBL    = build_code_table(MODE_SQUARE);
    localparam code_tbl_t SINE_TBL      = build_code_table(MODE_SINE);

endpackage

`default_nettype wire

### hdl/mwdg_sequencer.sv
// Sample sequencer: hold counter, sample index and started flag, with the
// next-state logic for one tick. Depends on mwdg_pkg.
`default_nettype none

module mwdg_sequencer
    import mwdg_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic              restart,
    input  wire logic [2:0]        wave_mode,
    input  wire logic [HOLD_W-1:0] sample_hold,
    input  wire logic [HOLD_W-1:0] high_hold,
    input  wire logic [HOLD_W-1:0] low_hold,
    output seq_status_t            status
);

    logic [IDX_W-1:0]  index_reg, index_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic              started_reg;
    logic              fresh;
    logic              two_level;
    logic [HOLD_W-1:0] hold_sel;
    logic [HOLD_W:0]   hold_limit;
    logic [HOLD_W:0]   count_inc;
    logic [IDX_W:0]    index_inc;
    logic [IDX_W:0]    wave_len;

    always_comb begin
        two_level = (wave_mode == MODE_SQUARE) || (wave_mode == MODE_PULSE);
        if (two_level) begin
            hold_sel = (index_reg == '0) ? high_hold : low_hold;
        end else begin
            hold_sel = sample_hold;
        end
        // A hold of zero behaves as a hold of one tick.
        hold_limit = (hold_sel == '0) ? (HOLD_W+1)'(1) : {1'b0, hold_sel};

        case (wave_mode)
            MODE_RAMP_UP, MODE_RAMP_DOWN: wave_len = (IDX_W+1)'(RAMP_STEPS);
            MODE_SQUARE, MODE_PULSE:      wave_len = (IDX_W+1)'(2);
            MODE_SINE:                    wave_len = (IDX_W+1)'(SINE_STEPS);
            default:                      wave_len = (IDX_W+1)'(TRIANGLE_STEPS);
        endcase

        count_inc = {1'b0, hold_reg} + (HOLD_W+1)'(1);
        index_inc = {1'b0, index_reg} + (IDX_W+1)'(1);

        index_next = index_reg;
        hold_next  = hold_reg;
        fresh      = 1'b0;
        if (restart || !started_reg) begin
            index_next = '0;
            hold_next  = '0;
            fresh      = 1'b1;
        end else if (count_inc >= hold_limit) begin
            index_next = (index_inc >= wave_len) ? '0 : index_inc[IDX_W-1:0];
            hold_next  = '0;
            fresh      = 1'b1;
        end else begin
            hold_next = count_inc[HOLD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg   <= '0;
            hold_reg    <= '0;
            started_reg <= 1'b0;
        end else if (step) begin
            index_reg   <= index_next;
            hold_reg    <= hold_next;
            started_reg <= 1'b1;
        end
    end

    assign status = '{index_next: index_next, fresh: fresh, index: index_reg};

endmodule

`default_nettype wire

### hdl/mwdg_sample_map.sv
// Sample map: turns a mode and a sample index into the 8-bit code and the
// 16-bit DAC command word. Depends on the code tables in mwdg_pkg.
`default_nettype none

module mwdg_sample_map
    import mwdg_pkg::*;
(
    input  wire logic [2:0]       wave_mode,
    input  wire logic [IDX_W-1:0] index,
    output logic [CODE_W-1:0]     code,
    output logic [DAC_W-1:0]      dac_word
);

    always_comb begin
        case (wave_mode)
            MODE_RAMP_UP:            code = RAMP_UP_TBL[index];
            MODE_RAMP_DOWN:          code = RAMP_DOWN_TBL[index];
            MODE_SQUARE, MODE_PULSE: code = SQUARE_TBL[index];
            MODE_SINE:               code = SINE_TBL[index];
            default:                 code = TRIANGLE_TBL[index];
        endcase
        // Low 12 bits are code*16+15, i.e. the code with four ones below it.
        dac_word = {DAC_PREFIX, code, DAC_FILL};
    end

endmodule

`default_nettype wire

### hdl/multi_waveform_dac_generator_core.sv
// Top level of the lookup-table waveform generator: configuration registers,
// handshakes and result register. Depends on mwdg_pkg, mwdg_sequencer,
// mwdg_sample_map and the assertion macro header.
`default_nettype none

// Each input transaction is one timer tick; each tick yields exactly one
// result transaction carrying the sample code in force after that tick, its
// DAC command word (0x3 in the top nibble, code*16+15 below) and a flag that
// marks the first tick of a new sample. A tick is taken in every cycle in
// which s_ready is high: the sequencer updates its hold counter and sample
// index, the code tables are read, and the result is captured in the output
// register at the accepting edge, so it is offered in the next cycle. The
// rate is set by the combinational counter compare, index advance and table
// read. s_ready stays high while the output register is empty or its
// transaction is being taken in the same cycle, so results stream at one per
// cycle when m_ready is held high. Configuration writes act on the next tick;
// the hold counter and index are kept across them. The first tick after reset,
// and any tick with restart set, starts the waveform at its first sample.

`include "multi_waveform_dac_generator_core_assert.svh"

module multi_waveform_dac_generator_core
    import mwdg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wr_data,
    // Tick channel.
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_restart,
    // Result channel.
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [DAC_W-1:0]          m_dac_word,
    output logic [CODE_W-1:0]         m_sample_code,
    output logic                      m_new_sample
);

    // Configuration registers.
    logic [2:0]        wave_mode_reg;
    logic [HOLD_W-1:0] sample_hold_reg;
    logic [HOLD_W-1:0] high_hold_reg;
    logic [HOLD_W-1:0] low_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg   <= MODE_TRIANGLE;
            sample_hold_reg <= SAMPLE_HOLD_RESET;
            high_hold_reg   <= HIGH_HOLD_RESET;
            low_hold_reg    <= LOW_HOLD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WAVE_MODE:   wave_mode_reg   <= cfg_wr_data[2:0];
                CFG_SAMPLE_HOLD: sample_hold_reg <= cfg_wr_data[HOLD_W-1:0];
                CFG_HIGH_HOLD:   high_hold_reg   <= cfg_wr_data[HOLD_W-1:0];
                CFG_LOW_HOLD:    low_hold_reg    <= cfg_wr_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // A tick is taken whenever the result register is free or draining.
    logic m_valid_reg, m_valid_next;
    logic accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    seq_status_t        seq;
    logic [CODE_W-1:0]  code;
    logic [DAC_W-1:0]   dac_word;

    mwdg_sequencer u_sequencer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .restart     (s_restart),
        .wave_mode   (wave_mode_reg),
        .sample_hold (sample_hold_reg),
        .high_hold   (high_hold_reg),
        .low_hold    (low_hold_reg),
        .status      (seq)
    );

    // The code is looked up for the index that this tick leaves behind.
    mwdg_sample_map u_sample_map (
        .wave_mode (wave_mode_reg),
        .index     (seq.index_next),
        .code      (code),
        .dac_word  (dac_word)
    );

    // Result register: payload needs no reset, only the valid flag does.
    logic [DAC_W-1:0]  dac_word_reg;
    logic [CODE_W-1:0] sample_code_reg;
    logic              new_sample_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dac_word_reg    <= dac_word;
            sample_code_reg <= code;
            new_sample_reg  <= seq.fresh;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dac_word    = dac_word_reg;
    assign m_sample_code = sample_code_reg;
    assign m_new_sample  = new_sample_reg;

    // Every accepted tick leaves a result in the output register.
    `MWDG_ASSERT_NEXT(a_tick_gives_result, aclk, aresetn, accept, m_valid)

    // A restart tick returns to the first sample and flags a new sample.
    `MWDG_ASSERT_NEXT(a_restart_to_first, aclk, aresetn, accept && s_restart,
                      seq.index == '0 && m_new_sample)

    // The command word always carries the prefix and the code shown beside it.
    `MWDG_ASSERT_NOW(a_word_matches_code, aclk, aresetn, m_valid,
                     m_dac_word == {DAC_PREFIX, m_sample_code, DAC_FILL})

endmodule

`default_nettype wire

### bench/tb_multi_waveform_dac_generator_core.sv
// Self-checking testbench for multi_waveform_dac_generator_core: directed table, then random ticks.
// Depends on mwdg_pkg for port widths, mode codes and register indexes; the RTL is the only
// other thing it needs.
module tb_multi_waveform_dac_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mwdg_pkg::*;

    // Run shape. The random part stops after RANDOM_TICKS accepted ticks; the last
    // QUIET_TICKS of it run without any idling on either side.
    localparam int unsigned RANDOM_TICKS  = 1300;
    localparam int unsigned QUIET_TICKS   = 150;
    localparam int unsigned STALL_AT_TICK = 450;
    localparam int unsigned LONG_HOLD     = 40;
    localparam int unsigned SETTLE_CYCLES = 3;
    localparam int unsigned TAIL_CYCLES   = 10;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    // Values of the 3-bit mode field that name no waveform; they behave as triangle.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Fixed pieces of the DAC command word and the square/pulse high level.
    localparam logic [3:0] DAC_CMD_NIBBLE  = 4'h3;
    localparam logic [3:0] DAC_LOW_NIBBLE  = 4'hF;
    localparam int unsigned FULL_SCALE     = 255;
    localparam int unsigned SINE_POINTS    = 96;

    // One period of the sine waveform.
    localparam logic [7:0] SINE_LEVELS [SINE_POINTS] = '{
        8'd127, 8'd135, 8'd143, 8'd151, 8'd159, 8'd156, 8'd166, 8'd174,
        8'd181, 8'd188, 8'd195, 8'd202, 8'd214, 8'd220, 8'd225, 8'd230,
        8'd234, 8'd238, 8'd242, 8'd245, 8'd248, 8'd252, 8'd253, 8'd254,
        8'd254, 8'd253, 8'd252, 8'd250, 8'd248, 8'd245, 8'd242, 8'd238,
        8'd230, 8'd225, 8'd220, 8'd214, 8'd208, 8'd202, 8'd195, 8'd188,
        8'd181, 8'd174, 8'd166, 8'd159, 8'd151, 8'd145, 8'd135, 8'd127,
        8'd119, 8'd111, 8'd103, 8'd95,  8'd88,  8'd80,  8'd73,  8'd66,
        8'd59,  8'd52,  8'd46,  8'd40,  8'd34,  8'd29,  8'd24,  8'd16,
        8'd12,  8'd9,   8'd6,   8'd4,   8'd2,   8'd1,   8'd0,   8'd0,
        8'd0,   8'd1,   8'd2,   8'd4,   8'd6,   8'd9,   8'd12,  8'd16,
        8'd20,  8'd24,  8'd29,  8'd34,  8'd40,  8'd46,  8'd52,  8'd59,
        8'd66,  8'd73,  8'd80,  8'd88,  8'd95,  8'd103, 8'd111, 8'd119
    };

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [DAC_W-1:0]  dac_word;
        logic [CODE_W-1:0] sample_code;
        logic              new_sample;
    } dac_sample_t;

    // The directed table holds two kinds of rows: a register write, made while the
    // block is idle, and a tick, optionally with its result typed in by hand.
    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     reg_val;
        logic                 restart;
        logic                 typed;
        dac_sample_t          want;
    } directed_row_t;

    // Every input is at a known level from time zero.
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_restart   = 1'b0;
    logic                 m_ready     = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [DAC_W-1:0]     m_dac_word;
    logic [CODE_W-1:0]    m_sample_code;
    logic                 m_new_sample;

    // Shadow copy of the configuration registers, at their reset values.
    logic [2:0]        cur_mode        = MODE_TRIANGLE;
    logic [HOLD_W-1:0] cur_sample_hold = 16'd20000;
    logic [HOLD_W-1:0] cur_high_hold   = 16'd100;
    logic [HOLD_W-1:0] cur_low_hold    = 16'd100;

    // Generator state as the predictor tracks it.
    logic [IDX_W-1:0]  gen_index      = '0;
    logic [HOLD_W-1:0] gen_hold_count = '0;
    logic              gen_started    = 1'b0;

    dac_sample_t   expected_samples[$];
    directed_row_t directed_rows[$];

    // A directed row with a typed result arms this override for its own tick.
    logic        literal_armed = 1'b0;
    dac_sample_t literal_sample;

    // Idling controls shared by the stimulus and the result sink.
    logic        sender_gaps     = 1'b0;
    logic        sink_gaps       = 1'b0;
    logic        long_hold_req   = 1'b0;
    logic        long_hold_taken = 1'b0;
    int unsigned sink_wait       = 0;

    int unsigned fault_count  = 0;
    int unsigned random_sent  = 0;
    int unsigned cycle_count  = 0;

    multi_waveform_dac_generator_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dac_word    (m_dac_word),
        .m_sample_code (m_sample_code),
        .m_new_sample  (m_new_sample)
    );

    always #6 aclk = ~aclk;

    // Number of samples in one period of a waveform. Square and pulse have two
    // samples, high then low; the spare modes fall back to triangle.
    function automatic int unsigned wave_len(input logic [2:0] mode);
        case (mode)
            MODE_RAMP_UP, MODE_RAMP_DOWN: return RAMP_STEPS;
            MODE_SQUARE, MODE_PULSE:      return 2;
            MODE_SINE:                    return SINE_STEPS;
            default:                      return TRIANGLE_STEPS;
        endcase
    endfunction

    // Ticks a sample is held. A register of zero still holds for one tick.
    function automatic int unsigned hold_ticks(input logic [2:0] mode,
                                               input logic [IDX_W-1:0] idx);
        logic [HOLD_W-1:0] h;
        if (mode == MODE_SQUARE || mode == MODE_PULSE) begin
            h = (idx == 0) ? cur_high_hold : cur_low_hold;
        end else begin
            h = cur_sample_hold;
        end
        return (h == 0) ? 1 : h;
    endfunction

    // Sample code at an index. An index past the end of the current waveform, which
    // a mode change can leave behind, reads as the first sample.
    function automatic logic [CODE_W-1:0] level_at(input logic [2:0] mode,
                                                   input logic [IDX_W-1:0] idx);
        int unsigned k;
        int unsigned v;
        k = (idx < wave_len(mode)) ? idx : 0;
        case (mode)
            MODE_RAMP_UP:             v = k * PEAK_CODE / RAMP_STEPS;
            MODE_RAMP_DOWN:           v = (RAMP_STEPS - k) * PEAK_CODE / RAMP_STEPS;
            MODE_SQUARE, MODE_PULSE:  v = (k == 0) ? FULL_SCALE : 0;
            MODE_SINE:                v = SINE_LEVELS[k % SINE_POINTS];
            default: begin
                if (k < TRIANGLE_STEPS / 2) begin
                    v = k * PEAK_CODE / TRIANGLE_STEPS;
                end else begin
                    v = (TRIANGLE_STEPS - k) * PEAK_CODE / TRIANGLE_STEPS;
                end
            end
        endcase
        return v[CODE_W-1:0];
    endfunction

    // Advances the generator by one tick and returns the result that tick produces.
    // The very first tick after reset and any tick with restart set go back to the
    // first sample; otherwise the hold counter advances, and when it runs out it
    // steps the index, which wraps at the end of the waveform.
    function automatic dac_sample_t advance_generator(input logic restart);
        dac_sample_t r;
        int unsigned nxt;
        int unsigned ni;
        r.new_sample = 1'b0;
        if (restart || !gen_started) begin
            gen_index      = '0;
            gen_hold_count = '0;
            gen_started    = 1'b1;
            r.new_sample   = 1'b1;
        end else begin
            nxt = gen_hold_count + 1;
            if (nxt >= hold_ticks(cur_mode, gen_index)) begin
                ni             = gen_index + 1;
                gen_index      = (ni >= wave_len(cur_mode)) ? '0 : ni[IDX_W-1:0];
                gen_hold_count = '0;
                r.new_sample   = 1'b1;
            end else begin
                gen_hold_count = nxt[HOLD_W-1:0];
            end
        end
        r.sample_code = level_at(cur_mode, gen_index);
        r.dac_word    = {DAC_CMD_NIBBLE, r.sample_code, DAC_LOW_NIBBLE};
        return r;
    endfunction

    task automatic note_fault(input string what, input int unsigned want,
                              input int unsigned got);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        end
    endtask

    // Scoreboard. At each rising edge the result transaction, if any, is checked
    // first, since it belongs to a tick accepted at an earlier edge; then a tick
    // accepted at this edge is run through the predictor.
    always @(posedge aclk) begin : scoreboard
        dac_sample_t got;
        dac_sample_t want;
        dac_sample_t calc;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_dac_word, m_sample_code, m_new_sample};
                if (expected_samples.size() == 0) begin
                    note_fault("result with nothing expected", 0, got.dac_word);
                end else begin
                    want = expected_samples.pop_front();
                    if (got.dac_word !== want.dac_word) begin
                        note_fault("dac_word", want.dac_word, got.dac_word);
                    end
                    if (got.sample_code !== want.sample_code) begin
                        note_fault("sample_code", want.sample_code, got.sample_code);
                    end
                    if (got.new_sample !== want.new_sample) begin
                        note_fault("new_sample", want.new_sample, got.new_sample);
                    end
                end
            end
            if (s_valid && s_ready) begin
                calc = advance_generator(s_restart);
                expected_samples.push_back(literal_armed ? literal_sample : calc);
            end
        end
    end

    // Result sink. It drops m_ready for random bursts when its idling is on, and
    // once in the run for a long stretch so that the output register fills and
    // the block must push back on the tick channel. Only one assignment to
    // m_ready is made per falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= 1'b0;
        end else if (long_hold_req && !long_hold_taken) begin
            long_hold_taken <= 1'b1;
            sink_wait       <= LONG_HOLD - 1;
            m_ready         <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
            sink_wait <= $urandom_range(0, 6);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog. The limit is many times the slowest correct run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_multi_waveform_dac_generator_core: done, errors");
            $finish;
        end
    end

    // Offers one tick and returns at the falling edge after it is accepted, with
    // s_valid still high, so that a following tick goes out back to back. A gap,
    // when one is taken, lowers s_valid at this edge and raises it at a later one.
    task automatic send_tick(input logic restart);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Stops offering ticks and waits until every expected result has come back.
    // The short settle afterwards keeps register writes clear of the last result.
    task automatic drain_results();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        while (expected_samples.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Writes one register and updates the shadow copy at the edge the write lands.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= sel;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (sel)
            CFG_WAVE_MODE:   cur_mode        = val[2:0];
            CFG_SAMPLE_HOLD: cur_sample_hold = val;
            CFG_HIGH_HOLD:   cur_high_hold   = val;
            CFG_LOW_HOLD:    cur_low_hold    = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Row builders for the directed table.
    function automatic directed_row_t wr(input logic [CFG_IDX_W-1:0] sel,
                                         input logic [CFG_W-1:0] val);
        directed_row_t r;
        r = '{ROW_WRITE, sel, val, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic directed_row_t tk(input logic restart);
        directed_row_t r;
        r = '{ROW_TICK, CFG_WAVE_MODE, '0, restart, 1'b0, '0};
        return r;
    endfunction

    function automatic directed_row_t tk_lit(input logic restart, input logic [DAC_W-1:0] word,
                                             input logic [CODE_W-1:0] code, input logic fresh);
        directed_row_t r;
        r = '{ROW_TICK, CFG_WAVE_MODE, '0, restart, 1'b1, {word, code, fresh}};
        return r;
    endfunction

    // Hold values: mostly short so that indices move through whole waveforms, with
    // zero, the maximum and full-range values mixed in.
    function automatic logic [HOLD_W-1:0] pick_hold();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return HOLD_W'($urandom());
            default: return HOLD_W'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        if ($urandom_range(0, 9) == 0) begin
            return ($urandom_range(0, 1) == 0) ? MODE_SPARE_LO : MODE_SPARE_HI;
        end
        return 3'($urandom_range(0, 5));
    endfunction

    initial begin : stimulus
        int unsigned phase_len;
        int unsigned k;
        logic [12:0] pad;
        logic        pulse_restart;

        // Directed part. Rows with a typed result cover the first tick after reset,
        // holding on a sample, restart, and the full-scale and half-scale codes;
        // the rest are checked against the predictor. Along the way it covers a zero
        // hold, the maximum holds, every waveform and both spare mode values.
        directed_rows.push_back(tk_lit(1'b0, 16'h300F, 8'd0, 1'b1));
        directed_rows.push_back(tk_lit(1'b0, 16'h300F, 8'd0, 1'b0));
        directed_rows.push_back(wr(CFG_SAMPLE_HOLD, 16'd0));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(tk_lit(1'b1, 16'h300F, 8'd0, 1'b1));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_SQUARE)));
        directed_rows.push_back(wr(CFG_HIGH_HOLD, 16'd1));
        directed_rows.push_back(wr(CFG_LOW_HOLD, 16'hFFFF));
        directed_rows.push_back(tk_lit(1'b1, 16'h3FFF, 8'd255, 1'b1));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_PULSE)));
        directed_rows.push_back(wr(CFG_HIGH_HOLD, 16'hFFFF));
        directed_rows.push_back(tk_lit(1'b1, 16'h3FFF, 8'd255, 1'b1));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_RAMP_DOWN)));
        directed_rows.push_back(tk_lit(1'b1, 16'h37FF, 8'd127, 1'b1));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_RAMP_UP)));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_SAMPLE_HOLD, 16'hFFFF));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_SINE)));
        directed_rows.push_back(tk_lit(1'b1, 16'h37FF, 8'd127, 1'b1));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_SAMPLE_HOLD, 16'd1));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_SPARE_LO)));
        directed_rows.push_back(tk(1'b0));
        directed_rows.push_back(wr(CFG_WAVE_MODE, CFG_W'(MODE_SPARE_HI)));
        directed_rows.push_back(tk(1'b0));

        // Reset is held low from time zero and released at a falling edge.
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_WRITE) begin
                drain_results();
                write_reg(directed_rows[n].reg_sel, directed_rows[n].reg_val);
            end else begin
                literal_armed  = directed_rows[n].typed;
                literal_sample = directed_rows[n].want;
                send_tick(directed_rows[n].restart);
                literal_armed  = 1'b0;
            end
        end

        // Random part, in phases. Each phase begins with the sender paused until
        // every result is back, then rewrites some registers and streams ticks. The
        // index and hold counter are kept across phases, so a mode change often
        // leaves an index beyond the new waveform's end. Idling on each side is
        // chosen per phase, and the closing stretch runs with none at all.
        while (random_sent < RANDOM_TICKS) begin
            drain_results();
            if ($urandom_range(0, 1) == 0) begin
                pad = 13'($urandom());
                write_reg(CFG_WAVE_MODE, {pad, pick_mode()});
            end
            if ($urandom_range(0, 1) == 0) write_reg(CFG_SAMPLE_HOLD, pick_hold());
            if ($urandom_range(0, 1) == 0) write_reg(CFG_HIGH_HOLD, pick_hold());
            if ($urandom_range(0, 1) == 0) write_reg(CFG_LOW_HOLD, pick_hold());

            phase_len = $urandom_range(20, 200);
            if (phase_len > RANDOM_TICKS - random_sent) phase_len = RANDOM_TICKS - random_sent;
            if (random_sent + QUIET_TICKS >= RANDOM_TICKS) begin
                sender_gaps = 1'b0;
                sink_gaps   = 1'b0;
            end else begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                sink_gaps   = ($urandom_range(0, 3) != 0);
            end

            for (k = 0; k < phase_len; k++) begin
                // The long hold-off is requested while ticks keep flowing.
                if (random_sent == STALL_AT_TICK) long_hold_req = 1'b1;
                pulse_restart = ($urandom_range(0, 39) == 0);
                send_tick(pulse_restart);
                random_sent++;
                if (random_sent + QUIET_TICKS == RANDOM_TICKS) begin
                    sender_gaps = 1'b0;
                    sink_gaps   = 1'b0;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fault_count == 0 && expected_samples.size() == 0) begin
            $display("tb_multi_waveform_dac_generator_core: done, clean");
        end else begin
            $display("tb_multi_waveform_dac_generator_core: done, errors");
        end
        $finish;
    end

endmodule

### multi_waveform_dac_generator_core.f
+incdir+hdl
hdl/mwdg_pkg.sv
hdl/mwdg_sequencer.sv
hdl/mwdg_sample_map.sv
hdl/multi_waveform_dac_generator_core.sv
bench/tb_multi_waveform_dac_generator_core.sv
